// File: hw/rtl/smam_pkg.sv
// shared constants, types and helper functions of the sparse matrix add merge block
`timescale 1ns / 1ps
`default_nettype none
package smam_pkg;

   localparam int COORD_BITS     = 10;
   localparam int IN_VALUE_BITS  = 16;
   localparam int OUT_VALUE_BITS = 17;
   localparam int DIM_BITS       = 11;
   localparam int REQ_BITS       = 2;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int MAX_DIM        = 1024;

   localparam int LIST_DEPTH_DEFAULT = 32;
   localparam int VALUE_BITS_DEFAULT = 16;

   localparam logic [REQ_BITS-1:0] REQ_LOAD_A = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_LOAD_B = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_MERGE  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_A_ROWS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_A_COLS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_B_ROWS = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_B_COLS = 2'd3;

   typedef struct packed {
      logic [DIM_BITS-1:0] a_rows;
      logic [DIM_BITS-1:0] a_cols;
      logic [DIM_BITS-1:0] b_rows;
      logic [DIM_BITS-1:0] b_cols;
   } dims_type;

   typedef struct packed {
      logic take_a;
      logic take_b;
   } pick_type;

   // stored value bits: a loaded value never carries more than the input field
   function automatic int store_width(int value_bits);
      return (value_bits < IN_VALUE_BITS) ? value_bits : IN_VALUE_BITS;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_coord(logic [COORD_BITS-1:0] c);
      logic [COORD_BITS-1:0] r;
      r = c;
      if (32'(c) >= MAX_DIM) begin
         r = COORD_BITS'(MAX_DIM - 1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/smam_req_if.sv
// request channel: load and merge commands
`timescale 1ns / 1ps
`default_nettype none
interface smam_req_if;
   import smam_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [REQ_BITS-1:0]          req_type;
   logic [COORD_BITS-1:0]        row;
   logic [COORD_BITS-1:0]        col;
   logic signed [IN_VALUE_BITS-1:0] value;

   modport source (output valid, req_type, row, col, value, input ready);
   modport sink   (input valid, req_type, row, col, value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/smam_rsp_if.sv
// response channel: merged entries and status
`timescale 1ns / 1ps
`default_nettype none
interface smam_rsp_if;
   import smam_pkg::*;

   logic                             valid;
   logic                             ready;
   logic [COORD_BITS-1:0]            out_row;
   logic [COORD_BITS-1:0]            out_col;
   logic signed [OUT_VALUE_BITS-1:0] out_value;
   logic [STATUS_BITS-1:0]           status;
   logic                             last;

   modport source (output valid, out_row, out_col, out_value, status, last, input ready);
   modport sink   (input valid, out_row, out_col, out_value, status, last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/smam_csr_if.sv
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface smam_csr_if;
   import smam_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DIM_BITS-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/smam_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module smam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output      logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/smam_cmp.sv
// shared coordinate compare and value add unit
`timescale 1ns / 1ps
`default_nettype none
module smam_cmp #(
   parameter int VALUE_BITS = 16,
   localparam int STORE_BITS = smam_pkg::store_width(VALUE_BITS),
   localparam int WORD_BITS = 2 * smam_pkg::COORD_BITS + STORE_BITS
) (
   input  wire logic [WORD_BITS-1:0]                    a_word,
   input  wire logic [WORD_BITS-1:0]                    b_word,
   input  wire logic                                    a_has,
   input  wire logic                                    b_has,
   output      smam_pkg::pick_type                      pick,
   output      logic [smam_pkg::COORD_BITS-1:0]         out_row,
   output      logic [smam_pkg::COORD_BITS-1:0]         out_col,
   output      logic signed [smam_pkg::OUT_VALUE_BITS-1:0] out_value
);
   import smam_pkg::*;

   logic [COORD_BITS-1:0]            a_row, a_col, b_row, b_col;
   logic [STORE_BITS-1:0]            a_val, b_val;
   logic signed [OUT_VALUE_BITS-1:0] a_ext, b_ext, a_term, b_term;

   assign a_row = a_word[WORD_BITS-1 -: COORD_BITS];
   assign a_col = a_word[STORE_BITS +: COORD_BITS];
   assign a_val = a_word[STORE_BITS-1:0];
   assign b_row = b_word[WORD_BITS-1 -: COORD_BITS];
   assign b_col = b_word[STORE_BITS +: COORD_BITS];
   assign b_val = b_word[STORE_BITS-1:0];

   assign a_ext = {{(OUT_VALUE_BITS-STORE_BITS){a_val[STORE_BITS-1]}}, a_val};
   assign b_ext = {{(OUT_VALUE_BITS-STORE_BITS){b_val[STORE_BITS-1]}}, b_val};

   always_comb begin
      priority if (!a_has) begin
         pick = '{take_a: 1'b0, take_b: 1'b1};
      end else if (!b_has) begin
         pick = '{take_a: 1'b1, take_b: 1'b0};
      end else if (a_row != b_row) begin
         pick.take_a = a_row < b_row;
         pick.take_b = !(a_row < b_row);
      end else if (a_col != b_col) begin
         pick.take_a = a_col < b_col;
         pick.take_b = !(a_col < b_col);
      end else begin
         pick = '{take_a: 1'b1, take_b: 1'b1};
      end
   end

   assign a_term    = pick.take_a ? a_ext : '0;
   assign b_term    = pick.take_b ? b_ext : '0;
   assign out_value = a_term + b_term;
   assign out_row   = pick.take_a ? a_row : b_row;
   assign out_col   = pick.take_a ? a_col : b_col;

endmodule
`default_nettype wire

// File: hw/rtl/smam_ctrl.sv
// merge sequencer: list counts, walk indexes and response register
`timescale 1ns / 1ps
`default_nettype none
module smam_ctrl #(
   parameter int LIST_DEPTH = 32,
   localparam int ADDR_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   input  wire logic [smam_pkg::REQ_BITS-1:0]           req_type,
   output      logic                                    req_ready,
   input  wire smam_pkg::dims_type                      dims,
   output      logic                                    a_we,
   output      logic                                    b_we,
   output      logic [ADDR_BITS-1:0]                    a_waddr,
   output      logic [ADDR_BITS-1:0]                    b_waddr,
   output      logic [ADDR_BITS-1:0]                    a_raddr,
   output      logic [ADDR_BITS-1:0]                    b_raddr,
   output      logic                                    a_has,
   output      logic                                    b_has,
   input  wire smam_pkg::pick_type                      pick,
   input  wire logic [smam_pkg::COORD_BITS-1:0]         cmp_row,
   input  wire logic [smam_pkg::COORD_BITS-1:0]         cmp_col,
   input  wire logic signed [smam_pkg::OUT_VALUE_BITS-1:0] cmp_value,
   output      logic                                    rsp_valid,
   input  wire logic                                    rsp_ready,
   output      logic [smam_pkg::COORD_BITS-1:0]         out_row,
   output      logic [smam_pkg::COORD_BITS-1:0]         out_col,
   output      logic signed [smam_pkg::OUT_VALUE_BITS-1:0] out_value,
   output      logic [smam_pkg::STATUS_BITS-1:0]        status,
   output      logic                                    last
);
   import smam_pkg::*;

   localparam int CNT_BITS = $clog2(LIST_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_FLAG = 4'b0010,
      S_READ = 4'b0100,
      S_STEP = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_BITS-1:0]        a_count_ff, a_count_in, b_count_ff, b_count_in;
   logic [CNT_BITS-1:0]        i_ff, i_in, j_ff, j_in;
   logic [CNT_BITS-1:0]        i_adv, j_adv;
   logic [STATUS_BITS-1:0]     flag_ff, flag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]      row_ff, row_in, col_ff, col_in;
   logic signed [OUT_VALUE_BITS-1:0] value_ff, value_in;
   logic [STATUS_BITS-1:0]     status_ff, status_in;
   logic                       last_ff, last_in;
   logic                       accept, out_free, load, a_full, b_full, dims_match, walk_done;

   assign req_ready  = state_ff == S_IDLE;
   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign a_full     = a_count_ff == CNT_BITS'(LIST_DEPTH);
   assign b_full     = b_count_ff == CNT_BITS'(LIST_DEPTH);
   assign dims_match = (dims.a_rows == dims.b_rows) && (dims.a_cols == dims.b_cols);

   assign a_we    = accept && (req_type == REQ_LOAD_A) && !a_full;
   assign b_we    = accept && (req_type == REQ_LOAD_B) && !b_full;
   assign a_waddr = a_count_ff[ADDR_BITS-1:0];
   assign b_waddr = b_count_ff[ADDR_BITS-1:0];
   assign a_raddr = i_ff[ADDR_BITS-1:0];
   assign b_raddr = j_ff[ADDR_BITS-1:0];
   assign a_has   = i_ff < a_count_ff;
   assign b_has   = j_ff < b_count_ff;

   assign i_adv     = i_ff + CNT_BITS'(pick.take_a);
   assign j_adv     = j_ff + CNT_BITS'(pick.take_b);
   assign walk_done = (i_adv == a_count_ff) && (j_adv == b_count_ff);

   always_comb begin
      state_in   = state_ff;
      a_count_in = a_count_ff;
      b_count_in = b_count_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      flag_in    = flag_ff;
      load       = 1'b0;
      row_in     = row_ff;
      col_in     = col_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      last_in    = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (a_we) begin
               a_count_in = a_count_ff + CNT_BITS'(1);
            end
            if (b_we) begin
               b_count_in = b_count_ff + CNT_BITS'(1);
            end
            if (accept && req_type == REQ_MERGE) begin
               i_in = '0;
               j_in = '0;
               if (!dims_match) begin
                  flag_in  = STATUS_MISMATCH;
                  state_in = S_FLAG;
               end else if (a_count_ff == '0 && b_count_ff == '0) begin
                  flag_in  = STATUS_EMPTY;
                  state_in = S_FLAG;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_FLAG: begin
            if (out_free) begin
               load       = 1'b1;
               row_in     = '0;
               col_in     = '0;
               value_in   = '0;
               status_in  = flag_ff;
               last_in    = 1'b1;
               a_count_in = '0;
               b_count_in = '0;
               state_in   = S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            if (out_free) begin
               load      = 1'b1;
               row_in    = cmp_row;
               col_in    = cmp_col;
               value_in  = cmp_value;
               status_in = STATUS_OK;
               last_in   = walk_done;
               i_in      = i_adv;
               j_in      = j_adv;
               if (walk_done) begin
                  a_count_in = '0;
                  b_count_in = '0;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_count_ff   <= '0;
         b_count_ff   <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         flag_ff      <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_count_ff   <= a_count_in;
         b_count_ff   <= b_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      col_ff    <= col_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_row   = row_ff;
   assign out_col   = col_ff;
   assign out_value = value_ff;
   assign status    = status_ff;
   assign last      = last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/sparse_matrix_add_merge.sv
// top level of the sparse matrix add block: coordinate list merge
//
//   channel   dir   handshake      word
//   req_bus   in    valid/ready    req_type, row, col, value
//   rsp_bus   out   valid/ready    out_row, out_col, out_value, status, last
//   csr_bus   in    valid/ready    index, data (always ready)
//
// a load is written into its list ram as it is taken; the block stays ready between loads
// a merge holds ready low until its last word sits in the output register
// each merged word goes through a list ram read, then a compare and add
// a dimension mismatch or two empty lists give a single closing word from the S_FLAG state
// a stall on rsp_bus holds the walk; synchronous reset empties both lists
`timescale 1ns / 1ps
`default_nettype none
module sparse_matrix_add_merge #(
   parameter int LIST_DEPTH = smam_pkg::LIST_DEPTH_DEFAULT,
   parameter int VALUE_BITS = smam_pkg::VALUE_BITS_DEFAULT
) (
   input wire logic    clock,
   input wire logic    reset,
   smam_req_if.sink    req_bus,
   smam_rsp_if.source  rsp_bus,
   smam_csr_if.sink    csr_bus
);
   import smam_pkg::*;

   localparam int STORE_BITS = store_width(VALUE_BITS);
   localparam int WORD_BITS  = 2 * COORD_BITS + STORE_BITS;
   localparam int ADDR_BITS  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   dims_type                         dims_ff, dims_in;
   pick_type                         pick;
   logic                             a_we, b_we, a_has, b_has;
   logic [ADDR_BITS-1:0]             a_waddr, b_waddr, a_raddr, b_raddr;
   logic [WORD_BITS-1:0]             wdata, a_rdata, b_rdata;
   logic [COORD_BITS-1:0]            cmp_row, cmp_col;
   logic signed [OUT_VALUE_BITS-1:0] cmp_value;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      dims_in = dims_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_A_ROWS: dims_in.a_rows = csr_bus.data;
            CSR_A_COLS: dims_in.a_cols = csr_bus.data;
            CSR_B_ROWS: dims_in.b_rows = csr_bus.data;
            CSR_B_COLS: dims_in.b_cols = csr_bus.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= '{a_rows: DIM_BITS'(1), a_cols: DIM_BITS'(1),
                      b_rows: DIM_BITS'(1), b_cols: DIM_BITS'(1)};
      end else begin
         dims_ff <= dims_in;
      end
   end

   assign wdata = {clamp_coord(req_bus.row), clamp_coord(req_bus.col),
                   req_bus.value[STORE_BITS-1:0]};

   smam_ram #(.WIDTH(WORD_BITS), .DEPTH(LIST_DEPTH)) u_a_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (wdata),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   smam_ram #(.WIDTH(WORD_BITS), .DEPTH(LIST_DEPTH)) u_b_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (wdata),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   smam_cmp #(.VALUE_BITS(VALUE_BITS)) u_cmp (
      .a_word    (a_rdata),
      .b_word    (b_rdata),
      .a_has     (a_has),
      .b_has     (b_has),
      .pick      (pick),
      .out_row   (cmp_row),
      .out_col   (cmp_col),
      .out_value (cmp_value)
   );

   smam_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .req_ready (req_bus.ready),
      .dims      (dims_ff),
      .a_we      (a_we),
      .b_we      (b_we),
      .a_waddr   (a_waddr),
      .b_waddr   (b_waddr),
      .a_raddr   (a_raddr),
      .b_raddr   (b_raddr),
      .a_has     (a_has),
      .b_has     (b_has),
      .pick      (pick),
      .cmp_row   (cmp_row),
      .cmp_col   (cmp_col),
      .cmp_value (cmp_value),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .out_row   (rsp_bus.out_row),
      .out_col   (rsp_bus.out_col),
      .out_value (rsp_bus.out_value),
      .status    (rsp_bus.status),
      .last      (rsp_bus.last)
   );

   // a merge keeps the block busy in the cycle after it is taken
   a_merge_busy: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.req_type == REQ_MERGE |=> !req_bus.ready)
      else $error("request taken right after a merge");

   // ready returns only with the closing word of a merge waiting
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(req_bus.ready) && !$past(reset) |-> rsp_bus.valid && rsp_bus.last)
      else $error("merge ended without a last word");

   // error and empty words close their merge
   a_flag_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.status != STATUS_OK |-> rsp_bus.last)
      else $error("status word without last");

   // both lists can never be written in one cycle
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      a_we |-> !b_we && req_bus.req_type == REQ_LOAD_A)
      else $error("list write mismatch");

endmodule
`default_nettype wire

// File: tb/sparse_matrix_add_merge_tb.sv
// self-checking bench for the sparse matrix add merge block: directed table, then random merges
`timescale 1ns / 1ps
module sparse_matrix_add_merge_tb;
   import smam_pkg::*;

   localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
   localparam int LIST_SLOTS  = LIST_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;
   localparam int HOLD_LEN    = 300;

   typedef struct {
      logic [REQ_BITS-1:0]             kind;
      logic [COORD_BITS-1:0]           row;
      logic [COORD_BITS-1:0]           col;
      logic signed [IN_VALUE_BITS-1:0] value;
   } req_word_type;

   typedef struct {
      logic [COORD_BITS-1:0]            row;
      logic [COORD_BITS-1:0]            col;
      logic signed [OUT_VALUE_BITS-1:0] value;
      logic [STATUS_BITS-1:0]           status;
      logic                             last;
   } rsp_word_type;

   typedef struct {
      bit                        is_csr;
      logic [CSR_INDEX_BITS-1:0] csr_index;
      logic [DIM_BITS-1:0]       csr_data;
      req_word_type              word;
      bit                        fixed;
      rsp_word_type              fixed_word;
   } table_row_type;

   logic clock;
   logic reset;

   smam_req_if req_bus ();
   smam_rsp_if rsp_bus ();
   smam_csr_if csr_bus ();

   sparse_matrix_add_merge u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // list contents and dimensions as the block should hold them
   logic [DIM_BITS-1:0]             dim_a_rows, dim_a_cols, dim_b_rows, dim_b_cols;
   logic [COORD_BITS-1:0]           list_a_row [LIST_SLOTS];
   logic [COORD_BITS-1:0]           list_a_col [LIST_SLOTS];
   logic signed [IN_VALUE_BITS-1:0] list_a_val [LIST_SLOTS];
   logic [COORD_BITS-1:0]           list_b_row [LIST_SLOTS];
   logic [COORD_BITS-1:0]           list_b_col [LIST_SLOTS];
   logic signed [IN_VALUE_BITS-1:0] list_b_val [LIST_SLOTS];
   int                              count_a, count_b;

   rsp_word_type  merged_due [$];
   table_row_type steps [$];

   int          mismatch_count;
   int          items_sent;
   int          cycle_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int          hold_request;
   int          hold_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic rsp_word_type make_rsp(input logic [COORD_BITS-1:0] r,
                                             input logic [COORD_BITS-1:0] c,
                                             input logic [OUT_VALUE_BITS-1:0] v,
                                             input logic [STATUS_BITS-1:0] st,
                                             input logic lst);
      rsp_word_type e;
      e.row    = r;
      e.col    = c;
      e.value  = v;
      e.status = st;
      e.last   = lst;
      return e;
   endfunction

   function automatic req_word_type make_req(input logic [REQ_BITS-1:0] k, input int r,
                                             input int c,
                                             input logic signed [IN_VALUE_BITS-1:0] v);
      req_word_type w;
      w.kind  = k;
      w.row   = COORD_BITS'(r);
      w.col   = COORD_BITS'(c);
      w.value = v;
      return w;
   endfunction

   function automatic table_row_type req_row(input logic [REQ_BITS-1:0] k, input int r,
                                             input int c, input int v);
      table_row_type t;
      t.is_csr     = 1'b0;
      t.csr_index  = CSR_A_ROWS;
      t.csr_data   = '0;
      t.word       = make_req(k, r, c, IN_VALUE_BITS'(v));
      t.fixed      = 1'b0;
      t.fixed_word = make_rsp('0, '0, '0, STATUS_OK, 1'b0);
      return t;
   endfunction

   function automatic table_row_type fixed_row(input logic [REQ_BITS-1:0] k, input int er,
                                               input int ec, input int ev,
                                               input logic [STATUS_BITS-1:0] es);
      table_row_type t;
      t            = req_row(k, 0, 0, 0);
      t.fixed      = 1'b1;
      t.fixed_word = make_rsp(COORD_BITS'(er), COORD_BITS'(ec), OUT_VALUE_BITS'(ev), es, 1'b1);
      return t;
   endfunction

   function automatic table_row_type csr_row(input logic [CSR_INDEX_BITS-1:0] idx,
                                             input int d);
      table_row_type t;
      t           = req_row(REQ_LOAD_A, 0, 0, 0);
      t.is_csr    = 1'b1;
      t.csr_index = idx;
      t.csr_data  = DIM_BITS'(d);
      return t;
   endfunction

   function automatic int pick_coord();
      case ($urandom_range(0, 3))
         0, 1: return $urandom_range(0, 3);
         2: return $urandom_range(0, 1023);
         default: return $urandom_range(1020, 1023);
      endcase
   endfunction

   function automatic logic signed [IN_VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return IN_VALUE_BITS'($urandom);
      endcase
   endfunction

   // predicted effect of one accepted request word
   task automatic apply_to_lists(input req_word_type w);
      int           i;
      int           j;
      logic         take_a;
      logic         take_b;
      rsp_word_type e;
      case (w.kind)
         REQ_LOAD_A: begin
            if (count_a < LIST_SLOTS) begin
               list_a_row[count_a] = w.row;
               list_a_col[count_a] = w.col;
               list_a_val[count_a] = w.value;
               count_a++;
            end
         end
         REQ_LOAD_B: begin
            if (count_b < LIST_SLOTS) begin
               list_b_row[count_b] = w.row;
               list_b_col[count_b] = w.col;
               list_b_val[count_b] = w.value;
               count_b++;
            end
         end
         REQ_MERGE: begin
            if (dim_a_rows != dim_b_rows || dim_a_cols != dim_b_cols) begin
               merged_due.push_back(make_rsp('0, '0, '0, STATUS_MISMATCH, 1'b1));
            end else if (count_a == 0 && count_b == 0) begin
               merged_due.push_back(make_rsp('0, '0, '0, STATUS_EMPTY, 1'b1));
            end else begin
               i = 0;
               j = 0;
               while (i < count_a || j < count_b) begin
                  if (i >= count_a) begin
                     take_a = 1'b0;
                     take_b = 1'b1;
                  end else if (j >= count_b) begin
                     take_a = 1'b1;
                     take_b = 1'b0;
                  end else if (list_a_row[i] != list_b_row[j]) begin
                     take_a = list_a_row[i] < list_b_row[j];
                     take_b = !take_a;
                  end else if (list_a_col[i] != list_b_col[j]) begin
                     take_a = list_a_col[i] < list_b_col[j];
                     take_b = !take_a;
                  end else begin
                     take_a = 1'b1;
                     take_b = 1'b1;
                  end
                  if (take_a && take_b) begin
                     e = make_rsp(list_a_row[i], list_a_col[i],
                                  {list_a_val[i][IN_VALUE_BITS-1], list_a_val[i]} +
                                  {list_b_val[j][IN_VALUE_BITS-1], list_b_val[j]},
                                  STATUS_OK, 1'b0);
                     i++;
                     j++;
                  end else if (take_a) begin
                     e = make_rsp(list_a_row[i], list_a_col[i],
                                  {list_a_val[i][IN_VALUE_BITS-1], list_a_val[i]},
                                  STATUS_OK, 1'b0);
                     i++;
                  end else begin
                     e = make_rsp(list_b_row[j], list_b_col[j],
                                  {list_b_val[j][IN_VALUE_BITS-1], list_b_val[j]},
                                  STATUS_OK, 1'b0);
                     j++;
                  end
                  e.last = (i >= count_a) && (j >= count_b);
                  merged_due.push_back(e);
               end
            end
            count_a = 0;
            count_b = 0;
         end
         default: ;
      endcase
   endtask

   task automatic send_req(input req_word_type w);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= w.kind;
      req_bus.row      <= w.row;
      req_bus.col      <= w.col;
      req_bus.value    <= w.value;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      if (w.kind != REQ_UNUSED) items_sent++;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      case (idx)
         CSR_A_ROWS: dim_a_rows = d;
         CSR_A_COLS: dim_a_cols = d;
         CSR_B_ROWS: dim_b_rows = d;
         CSR_B_COLS: dim_b_cols = d;
         default: ;
      endcase
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (merged_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_dims(input logic [DIM_BITS-1:0] ar, input logic [DIM_BITS-1:0] ac,
                             input logic [DIM_BITS-1:0] br, input logic [DIM_BITS-1:0] bc);
      settle();
      csr_write(CSR_A_ROWS, ar);
      csr_write(CSR_A_COLS, ac);
      csr_write(CSR_B_ROWS, br);
      csr_write(CSR_B_COLS, bc);
      csr_bus.valid <= 1'b0;
   endtask

   // loads two lists that share some coordinates, then merges; noise may swap list ends or mix in unused requests
   task automatic run_sequence(input bit fill);
      req_word_type a_words [$];
      req_word_type b_words [$];
      req_word_type mix [$];
      req_word_type w;
      int           n, r, c, own, noise, k;
      logic signed [IN_VALUE_BITS-1:0] va, vb;
      n     = fill ? 52 : $urandom_range(0, 8);
      noise = $urandom_range(0, 9);
      r     = pick_coord();
      c     = pick_coord();
      for (k = 0; k < n; k++) begin
         if (k > 0) begin
            if ($urandom_range(0, 1) == 0) begin
               c += $urandom_range(1, 3);
            end else begin
               r += $urandom_range(1, 2);
               c = pick_coord();
            end
         end
         own = fill ? $urandom_range(0, 3) : $urandom_range(1, 3);
         va  = pick_value();
         vb  = ($urandom_range(0, 3) == 0) ? -va : pick_value();
         if (own != 2) a_words.push_back(make_req(REQ_LOAD_A, r, c, va));
         if (own != 1) b_words.push_back(make_req(REQ_LOAD_B, r, c, vb));
      end
      // out of order lists
      if (noise == 0 && a_words.size() > 1) begin
         w = a_words[0];
         a_words[0] = a_words[a_words.size()-1];
         a_words[a_words.size()-1] = w;
      end
      if (noise == 1 && b_words.size() > 1) begin
         w = b_words[0];
         b_words[0] = b_words[b_words.size()-1];
         b_words[b_words.size()-1] = w;
      end
      while (a_words.size() != 0 || b_words.size() != 0) begin
         if (b_words.size() == 0 || (a_words.size() != 0 && $urandom_range(0, 1) == 0))
            mix.push_back(a_words.pop_front());
         else
            mix.push_back(b_words.pop_front());
         if (noise == 2 && $urandom_range(0, 3) == 0)
            mix.push_back(make_req(REQ_UNUSED, $urandom, $urandom, IN_VALUE_BITS'($urandom)));
      end
      mix.push_back(make_req(REQ_MERGE, $urandom, $urandom, IN_VALUE_BITS'($urandom)));
      foreach (mix[k]) begin
         send_req(mix[k]);
         apply_to_lists(mix[k]);
      end
   endtask

   // result checking and receiver stalls
   always @(posedge clock) begin : rsp_side
      rsp_word_type got;
      rsp_word_type want;
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = make_rsp(rsp_bus.out_row, rsp_bus.out_col, rsp_bus.out_value,
                        rsp_bus.status, rsp_bus.last);
         if (merged_due.size() == 0) begin
            $error("unexpected word row %0d col %0d value %0d status %0d last %0d",
                   got.row, got.col, got.value, got.status, got.last);
            mismatch_count++;
         end else begin
            want = merged_due.pop_front();
            if (got.row !== want.row) begin
               $error("out_row expected %0d actual %0d", want.row, got.row);
               mismatch_count++;
            end
            if (got.col !== want.col) begin
               $error("out_col expected %0d actual %0d", want.col, got.col);
               mismatch_count++;
            end
            if (got.value !== want.value) begin
               $error("out_value expected %0d actual %0d", want.value, got.value);
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status);
               mismatch_count++;
            end
            if (got.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, got.last);
               mismatch_count++;
            end
         end
      end
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int                  k, phase, s, start;
      int                  n0;
      logic [DIM_BITS-1:0] ar, ac, br, bc;
      mismatch_count = 0;
      items_sent     = 0;
      hold_request   = 0;
      hold_left      = 0;
      send_idle_pct  = 26;
      recv_idle_pct  = 62;
      dim_a_rows     = 11'd1;
      dim_a_cols     = 11'd1;
      dim_b_rows     = 11'd1;
      dim_b_cols     = 11'd1;
      count_a        = 0;
      count_b        = 0;

      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_LOAD_A;
      req_bus.row      <= '0;
      req_bus.col      <= '0;
      req_bus.value    <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.index    <= CSR_A_ROWS;
      csr_bus.data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // both lists empty after reset
      steps.push_back(fixed_row(REQ_MERGE, 0, 0, 0, STATUS_EMPTY));
      // extreme values and coordinates
      steps.push_back(req_row(REQ_LOAD_A, 0, 0, 32767));
      steps.push_back(req_row(REQ_LOAD_B, 0, 0, 32767));
      steps.push_back(fixed_row(REQ_MERGE, 0, 0, 65534, STATUS_OK));
      steps.push_back(req_row(REQ_LOAD_A, 1023, 1023, -32768));
      steps.push_back(req_row(REQ_LOAD_B, 1023, 1023, -32768));
      steps.push_back(fixed_row(REQ_MERGE, 1023, 1023, -65536, STATUS_OK));
      // sum of zero still comes out
      steps.push_back(req_row(REQ_LOAD_A, 2, 3, 100));
      steps.push_back(req_row(REQ_LOAD_B, 2, 3, -100));
      steps.push_back(fixed_row(REQ_MERGE, 2, 3, 0, STATUS_OK));
      // unused request code leaves the lists alone
      steps.push_back(req_row(REQ_LOAD_A, 5, 6, 1));
      steps.push_back(req_row(REQ_UNUSED, 1023, 0, -1));
      steps.push_back(fixed_row(REQ_MERGE, 5, 6, 1, STATUS_OK));
      steps.push_back(req_row(REQ_LOAD_A, 0, 1, 5));
      steps.push_back(req_row(REQ_LOAD_A, 1, 0, 7));
      steps.push_back(req_row(REQ_LOAD_B, 0, 0, 3));
      steps.push_back(req_row(REQ_LOAD_B, 1, 0, -7));
      steps.push_back(req_row(REQ_MERGE, 0, 0, 0));
      // unsorted list
      steps.push_back(req_row(REQ_LOAD_A, 9, 9, 1));
      steps.push_back(req_row(REQ_LOAD_A, 4, 4, 2));
      steps.push_back(req_row(REQ_LOAD_B, 4, 4, 3));
      steps.push_back(req_row(REQ_MERGE, 0, 0, 0));
      // dimension mismatch, then out of range dimensions
      steps.push_back(csr_row(CSR_A_ROWS, 1024));
      steps.push_back(req_row(REQ_LOAD_A, 1, 1, 1));
      steps.push_back(fixed_row(REQ_MERGE, 0, 0, 0, STATUS_MISMATCH));
      steps.push_back(csr_row(CSR_B_ROWS, 1024));
      steps.push_back(csr_row(CSR_A_COLS, 0));
      steps.push_back(csr_row(CSR_B_COLS, 0));
      steps.push_back(fixed_row(REQ_MERGE, 0, 0, 0, STATUS_EMPTY));
      steps.push_back(csr_row(CSR_B_COLS, 2047));
      steps.push_back(req_row(REQ_LOAD_B, 7, 7, -5));
      steps.push_back(fixed_row(REQ_MERGE, 0, 0, 0, STATUS_MISMATCH));
      steps.push_back(csr_row(CSR_A_COLS, 2047));
      steps.push_back(fixed_row(REQ_MERGE, 0, 0, 0, STATUS_EMPTY));

      for (k = 0; k < steps.size(); k++) begin
         if (steps[k].is_csr) begin
            if (k == 0 || !steps[k-1].is_csr) settle();
            csr_write(steps[k].csr_index, steps[k].csr_data);
            if (k + 1 == steps.size() || !steps[k+1].is_csr) csr_bus.valid <= 1'b0;
         end else begin
            send_req(steps[k].word);
            n0 = merged_due.size();
            apply_to_lists(steps[k].word);
            if (steps[k].fixed) begin
               while (merged_due.size() > n0) void'(merged_due.pop_back());
               merged_due.push_back(steps[k].fixed_word);
            end
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (s = 0; s < 4; s++) begin
            case (s)
               0: begin
                  ar = $urandom_range(0, 1) ? 11'd1024 : 11'd1;
                  ac = $urandom_range(0, 1) ? 11'd1024 : 11'd1;
               end
               1: begin
                  ar = DIM_BITS'($urandom_range(1, 1024));
                  ac = DIM_BITS'($urandom_range(1, 1024));
               end
               2: begin
                  ar = $urandom_range(0, 1) ? 11'd0 : DIM_BITS'($urandom_range(1025, 2047));
                  ac = $urandom_range(0, 1) ? 11'd2047 : DIM_BITS'($urandom_range(1025, 2047));
               end
               default: begin
                  ar = DIM_BITS'($urandom_range(1, 1024));
                  ac = DIM_BITS'($urandom_range(1, 1024));
               end
            endcase
            br = ar;
            bc = ac;
            if (s == 3) begin
               if ($urandom_range(0, 1) == 0)
                  br = ar ^ DIM_BITS'(1 << $urandom_range(0, DIM_BITS - 1));
               else
                  bc = ac ^ DIM_BITS'(1 << $urandom_range(0, DIM_BITS - 1));
            end
            write_dims(ar, ac, br, bc);
            // long receiver hold-off while loads and merges keep coming
            if (phase == 0 && s == 1) hold_request = HOLD_LEN;
            start = items_sent;
            while (items_sent - start < ((s == 3) ? 12 : 24))
               run_sequence(phase == 0 && s == 2 && items_sent == start);
         end
      end

      settle();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
